>>> design/pnph_pkg.sv
// Package with payload types, function codes and status codes for the polyline block.
package pnph_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned OutBits   = CoordBits + FracBits;

  // Function codes.
  localparam logic [1:0] FuncAppend    = 2'd0;
  localparam logic [1:0] FuncClear     = 2'd1;
  localparam logic [1:0] FuncNearest   = 2'd2;
  localparam logic [1:0] FuncIntersect = 2'd3;

  // Status codes.
  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusFew  = 2'd2;

  typedef struct packed {
    logic [1:0]                  func;
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] qx;
    logic signed [CoordBits-1:0] qy;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [OutBits-1:0] near_x;
    logic signed [OutBits-1:0] near_y;
    logic                      hit;
  } out_item_t;

endpackage

>>> design/pnph_div.sv
// Restoring divider that produces one quotient bit per cycle.
module pnph_div #(
  parameter int unsigned NumBits = 42,
  parameter int unsigned DenBits = 34
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o,
  output logic               inexact_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DenBits:0]   trial;

  // One shift and subtract step.
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o    = done_q;
  assign quot_o    = quot_q;
  assign inexact_o = (rem_q != '0);

endmodule

>>> design/polyline_nearest_point_and_hit.sv
// Top level: vertex store, segment sequencer, shared multiplier and divider.
//
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_valid_i/ready_o | pnph_pkg::in_item_t
//  out     | output    | out_valid_o/ready_i| pnph_pkg::out_item_t
//
// Append and clear pass through the output state back to idle. A nearest query
// reads each segment's ends and runs the multiplier steps, then takes the nearer
// end vertex, or runs the bit-serial divider once per axis when the projection
// falls inside the segment; an intersect query checks one segment at a time and
// stops at the first hit. Reset clears the vertex count, the output valid and
// the sequencer only. The block takes no item while one is at work; a result
// waiting in the output register holds the sequencer in its output state.
module polyline_nearest_point_and_hit #(
  parameter int unsigned MaxVertices = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pnph_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pnph_pkg::out_item_t  out_data_o
);

  localparam int unsigned CB      = pnph_pkg::CoordBits;
  localparam int unsigned FB      = pnph_pkg::FracBits;
  localparam int unsigned OB      = pnph_pkg::OutBits;
  localparam int unsigned AddrBits = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned CntBits = $clog2(MaxVertices + 1);
  // Wide working width for products of differences.
  localparam int unsigned PW      = 2 * (CB + 1) + 2;
  localparam int unsigned NumBits = CB + 1 + FB + 1;
  localparam int unsigned DenBits = PW;
  localparam int unsigned SqBits  = 2 * (OB + 2) + 1;

  typedef enum logic [13:0] {
    StIdle  = 14'b00000000000001,
    StRd0   = 14'b00000000000010,
    StRd1   = 14'b00000000000100,
    StLoad  = 14'b00000000001000,
    StMul   = 14'b00000000010000,
    StDecid = 14'b00000000100000,
    StDivX  = 14'b00000001000000,
    StWaitX = 14'b00000010000000,
    StDivY  = 14'b00000100000000,
    StWaitY = 14'b00001000000000,
    StDist  = 14'b00010000000000,
    StCmp   = 14'b00100000000000,
    StNext  = 14'b01000000000000,
    StOut   = 14'b10000000000000
  } state_e;

  state_e state_q;

  pnph_pkg::in_item_t  item_q;
  pnph_pkg::out_item_t res_q, res_d;
  logic                out_valid_q;
  logic                out_free;
  logic [CntBits-1:0]  count_q;
  logic [CntBits-1:0]  seg_q;
  logic [2:0]          step_q;

  // Vertex memory.
  logic [2*CB-1:0] mem [MaxVertices];
  logic [2*CB-1:0] rd_q;
  logic [AddrBits-1:0] rd_addr;
  logic            mem_we;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AddrBits-1:0]] <= {item_q.px, item_q.py};
    end
    rd_q <= mem[rd_addr];
  end

  // Segment endpoints and working terms.
  logic signed [CB-1:0] bx_q, by_q, ex_q, ey_q;
  logic signed [PW-1:0] t_q [8];
  logic signed [PW-1:0] den_q, num_q, na_q, nb_q;
  logic signed [OB+1:0] cx_q, cy_q;
  logic signed [OB-1:0] bestx_q, besty_q;
  logic [SqBits-1:0]    best_q, dist_q;
  logic                 have_q;

  // Shared multiplier operands chosen by the step counter.
  logic signed [OB+2:0] ma, mb;
  logic signed [2*(OB+3)-1:0] prod;
  logic signed [CB:0] dx, dy, rx, ry, qbx, qby, cxx, cyy, ebx, eby;

  assign dx  = (CB+1)'(ex_q) - (CB+1)'(bx_q);
  assign dy  = (CB+1)'(ey_q) - (CB+1)'(by_q);
  assign rx  = (CB+1)'(item_q.px) - (CB+1)'(bx_q);
  assign ry  = (CB+1)'(item_q.py) - (CB+1)'(by_q);
  assign ebx = (CB+1)'(item_q.px) - (CB+1)'(ex_q);
  assign eby = (CB+1)'(item_q.py) - (CB+1)'(ey_q);
  assign qbx = (CB+1)'(item_q.px) - (CB+1)'(item_q.qx);
  assign qby = (CB+1)'(item_q.py) - (CB+1)'(item_q.qy);
  assign cxx = (CB+1)'(bx_q) - (CB+1)'(item_q.px);
  assign cyy = (CB+1)'(by_q) - (CB+1)'(item_q.py);

  logic signed [OB+2:0] ex_dist, ey_dist;
  assign ex_dist = (OB+3)'(cx_q) - (OB+3)'($signed({item_q.px, {FB{1'b0}}}));
  assign ey_dist = (OB+3)'(cy_q) - (OB+3)'($signed({item_q.py, {FB{1'b0}}}));

  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == StDist) begin
      ma = (step_q[0]) ? ey_dist : ex_dist;
      mb = ma;
    end else if (item_q.func == pnph_pkg::FuncNearest) begin
      unique case (step_q)
        3'd0: begin ma = (OB+3)'(dx);  mb = (OB+3)'(dx);  end
        3'd1: begin ma = (OB+3)'(dy);  mb = (OB+3)'(dy);  end
        3'd2: begin ma = (OB+3)'(dx);  mb = (OB+3)'(rx);  end
        3'd3: begin ma = (OB+3)'(dy);  mb = (OB+3)'(ry);  end
        3'd4: begin ma = (OB+3)'(rx);  mb = (OB+3)'(rx);  end
        3'd5: begin ma = (OB+3)'(ry);  mb = (OB+3)'(ry);  end
        3'd6: begin ma = (OB+3)'(ebx); mb = (OB+3)'(ebx); end
        default: begin ma = (OB+3)'(eby); mb = (OB+3)'(eby); end
      endcase
    end else begin
      unique case (step_q)
        3'd0: begin ma = (OB+3)'(dy);  mb = (OB+3)'(qbx); end
        3'd1: begin ma = (OB+3)'(dx);  mb = (OB+3)'(qby); end
        3'd2: begin ma = (OB+3)'(qby); mb = (OB+3)'(cxx); end
        3'd3: begin ma = (OB+3)'(qbx); mb = (OB+3)'(cyy); end
        3'd4: begin ma = (OB+3)'(dx);  mb = (OB+3)'(cyy); end
        3'd5: begin ma = (OB+3)'(dy);  mb = (OB+3)'(cxx); end
        default: begin ma = '0; mb = '0; end
      endcase
    end
  end

  assign prod = (2*(OB+3))'(ma) * (2*(OB+3))'(mb);

  // Divider for the projection fraction.
  logic               div_start;
  logic               div_done, div_inexact;
  logic [NumBits-1:0] div_quot;
  logic signed [CB:0] dsel;
  logic [CB:0]        dmag;
  logic [NumBits+DenBits-1:0] prod_num;
  logic [NumBits+DenBits-1:0] div_quot_w;

  assign dsel = (state_q == StDivX) ? dx : dy;
  assign dmag = dsel[CB] ? (CB+1)'(-dsel) : (CB+1)'(dsel);

  // Quotient floor(|d|*2^F*num/den) is split: first |d|*2^F*num, then divide.
  // The product can exceed the divider numerator width, so a longer divider
  // handles the full dividend.
  assign prod_num = (NumBits+DenBits)'({dmag, {FB{1'b0}}}) * (NumBits+DenBits)'(num_q);

  pnph_div #(
    .NumBits(NumBits + DenBits),
    .DenBits(DenBits)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (prod_num),
    .den_i    (den_q[DenBits-1:0]),
    .done_o   (div_done),
    .quot_o   (div_quot_w),
    .inexact_o(div_inexact)
  );

  assign div_quot = div_quot_w[NumBits-1:0];

  // Truncated axis value from base, sign of delta and quotient.
  function automatic logic signed [OB+1:0] axis_val(
    input logic signed [CB-1:0] b, input logic neg,
    input logic [NumBits-1:0] q, input logic inexact);
    logic signed [OB+1:0] base, lo;
    base = (OB+2)'($signed({b, {FB{1'b0}}}));
    if (!neg) begin
      lo = base + (OB+2)'(q);
      axis_val = (!inexact || lo >= 0) ? lo : lo + 1'b1;
    end else if (!inexact) begin
      axis_val = base - (OB+2)'(q);
    end else begin
      lo = base - (OB+2)'(q) - 1'b1;
      axis_val = (lo >= 0) ? lo : lo + 1'b1;
    end
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign rd_addr    = (state_q == StRd0) ? seg_q[AddrBits-1:0]
                                         : AddrBits'(seg_q + 1'b1);
  assign div_start  = (state_q == StDivX || state_q == StDivY) && (step_q == 3'd0);
  assign mem_we     = (state_q == StOut) && out_free
                      && (item_q.func == pnph_pkg::FuncAppend)
                      && (count_q < CntBits'(MaxVertices));

  // Sequencer.
  logic signed [PW-1:0] sb, se;
  logic                 in_a, in_b, den_pos;
  assign sb = t_q[4] + t_q[5];
  assign se = t_q[6] + t_q[7];
  assign den_pos = !den_q[PW-1];
  assign in_a = den_pos ? (na_q >= 0 && na_q <= den_q) : (na_q <= 0 && na_q >= den_q);
  assign in_b = den_pos ? (nb_q >= 0 && nb_q <= den_q) : (nb_q <= 0 && nb_q >= den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      seg_q       <= '0;
      step_q      <= '0;
    end else begin
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            seg_q <= '0;
            if ((in_data_i.func == pnph_pkg::FuncNearest
                 || in_data_i.func == pnph_pkg::FuncIntersect)
                && count_q >= CntBits'(2)) begin
              state_q <= StRd0;
            end else begin
              state_q <= StOut;
            end
          end
        end
        StRd0:  state_q <= StRd1;
        StRd1:  state_q <= StLoad;
        StLoad: begin
          state_q <= StMul;
          step_q  <= '0;
        end
        StMul: begin
          step_q <= step_q + 1'b1;
          if (step_q == 3'd7) state_q <= StDecid;
        end
        StDecid: begin
          step_q <= '0;
          if (item_q.func == pnph_pkg::FuncNearest) begin
            if (den_q > 0 && num_q >= 0 && num_q <= den_q) begin
              state_q <= StDivX;
            end else begin
              state_q <= StDist;
            end
          end else begin
            if (den_q != 0 && in_a && in_b) begin
              state_q <= StOut;
            end else begin
              state_q <= StNext;
            end
          end
        end
        StDivX:  state_q <= StWaitX;
        StWaitX: if (div_done) begin
          state_q <= StDivY;
        end
        StDivY:  state_q <= StWaitY;
        StWaitY: if (div_done) begin
          state_q <= StDist;
          step_q  <= '0;
        end
        StDist: begin
          step_q <= step_q + 1'b1;
          if (step_q == 3'd1) state_q <= StCmp;
        end
        StCmp: state_q <= StNext;
        StNext: begin
          seg_q <= seg_q + 1'b1;
          if (seg_q + CntBits'(2) >= count_q) begin
            state_q <= StOut;
          end else begin
            state_q <= StRd0;
          end
        end
        StOut: begin
          if (out_free) begin
            state_q <= StIdle;
            if (item_q.func == pnph_pkg::FuncAppend && count_q < CntBits'(MaxVertices)) begin
              count_q <= count_q + 1'b1;
            end else if (item_q.func == pnph_pkg::FuncClear) begin
              count_q <= '0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Result item for the current function.
  always_comb begin
    res_d = '0;
    unique case (item_q.func)
      pnph_pkg::FuncAppend: begin
        if (count_q >= CntBits'(MaxVertices)) res_d.status = pnph_pkg::StatusFull;
      end
      pnph_pkg::FuncClear: res_d.status = pnph_pkg::StatusOk;
      pnph_pkg::FuncNearest: begin
        if (count_q < CntBits'(2)) begin
          res_d.status = pnph_pkg::StatusFew;
        end else begin
          res_d.near_x = bestx_q;
          res_d.near_y = besty_q;
        end
      end
      pnph_pkg::FuncIntersect: begin
        if (count_q < CntBits'(2)) begin
          res_d.status = pnph_pkg::StatusFew;
        end else begin
          res_d.hit = (den_q != 0) && in_a && in_b && (seg_q + CntBits'(1) < count_q);
        end
      end
      default: res_d = '0;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
      have_q <= 1'b0;
      bestx_q <= '0;
      besty_q <= '0;
    end
    if (state_q == StRd1) begin
      bx_q <= rd_q[2*CB-1:CB];
      by_q <= rd_q[CB-1:0];
    end
    if (state_q == StLoad) begin
      ex_q <= rd_q[2*CB-1:CB];
      ey_q <= rd_q[CB-1:0];
    end
    if (state_q == StMul) begin
      t_q[step_q] <= prod[PW-1:0];
      if (item_q.func == pnph_pkg::FuncNearest) begin
        if (step_q == 3'd1) den_q <= t_q[0] + prod[PW-1:0];
        if (step_q == 3'd3) num_q <= t_q[2] + prod[PW-1:0];
      end else begin
        if (step_q == 3'd1) den_q <= t_q[0] - prod[PW-1:0];
        if (step_q == 3'd3) na_q  <= t_q[2] - prod[PW-1:0];
        if (step_q == 3'd5) nb_q  <= t_q[4] - prod[PW-1:0];
      end
    end
    if (state_q == StDecid && item_q.func == pnph_pkg::FuncNearest) begin
      if (sb < se) begin
        cx_q <= (OB+2)'($signed({bx_q, {FB{1'b0}}}));
        cy_q <= (OB+2)'($signed({by_q, {FB{1'b0}}}));
      end else begin
        cx_q <= (OB+2)'($signed({ex_q, {FB{1'b0}}}));
        cy_q <= (OB+2)'($signed({ey_q, {FB{1'b0}}}));
      end
    end
    if (state_q == StWaitX && div_done) begin
      cx_q <= axis_val(bx_q, dx[CB], div_quot, div_inexact);
    end
    if (state_q == StWaitY && div_done) begin
      cy_q <= axis_val(by_q, dy[CB], div_quot, div_inexact);
    end
    if (state_q == StDist) begin
      if (step_q == 3'd0) dist_q <= SqBits'(prod);
      else                dist_q <= dist_q + SqBits'(prod);
    end
    if (state_q == StCmp && (!have_q || dist_q < best_q)) begin
      have_q  <= 1'b1;
      best_q  <= dist_q;
      bestx_q <= cx_q[OB-1:0];
      besty_q <= cy_q[OB-1:0];
    end
    if (state_q == StOut && out_free) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

>>> bench/tb_polyline_nearest_point_and_hit.sv
// Testbench for the polyline nearest point and segment hit block.
`timescale 1ns / 100ps

module tb_polyline_nearest_point_and_hit;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned NumItems   = 1600;
  localparam int unsigned StallLimit = 200000;

  // Scoreboard: shadow vertex store, expected result queue and mismatch count.
  class polyline_scoreboard;
    longint              vert_x [StoreDepth];
    longint              vert_y [StoreDepth];
    int unsigned         vert_cnt;
    pnph_pkg::out_item_t expected_q [$];
    int unsigned         errors;

    function new();
      vert_cnt = 0;
      errors   = 0;
    endfunction

    // One axis of base + d * num / den in Q16.8, truncated toward zero.
    function longint axis_fix(longint b, longint d, longint num, longint den);
      longint base, prod, q, lo;
      base = b * 256;
      prod = ((d < 0) ? -d : d) * 256 * num;
      q    = prod / den;
      if (d >= 0) begin
        lo = base + q;
        if (prod % den == 0) return lo;
      end else begin
        if (prod % den == 0) return base - q;
        lo = base - q - 1;
      end
      return (lo >= 0) ? lo : lo + 1;
    endfunction

    // Candidate point of one segment for the query point, clamped to the ends.
    function void seg_candidate(int unsigned i, longint px, longint py,
                                output longint cx, output longint cy);
      longint bx, by, ex, ey, dx, dy, den, num, sb, se;
      bx  = vert_x[i];
      by  = vert_y[i];
      ex  = vert_x[i+1];
      ey  = vert_y[i+1];
      dx  = ex - bx;
      dy  = ey - by;
      den = dx * dx + dy * dy;
      num = dx * (px - bx) + dy * (py - by);
      if (den > 0 && num >= 0 && num <= den) begin
        cx = axis_fix(bx, dx, num, den);
        cy = axis_fix(by, dy, num, den);
      end else begin
        sb = (bx - px) * (bx - px) + (by - py) * (by - py);
        se = (ex - px) * (ex - px) + (ey - py) * (ey - py);
        cx = (sb < se) ? bx * 256 : ex * 256;
        cy = (sb < se) ? by * 256 : ey * 256;
      end
    endfunction

    function bit in_unit(longint n, longint den);
      if (den > 0) return n >= 0 && n <= den;
      return n <= 0 && n >= den;
    endfunction

    // Notes an accepted item and queues the result it should produce.
    function void note_item(pnph_pkg::in_item_t it);
      pnph_pkg::out_item_t e;
      longint    px, py, qx, qy, cx, cy, bestx, besty, sq_d, best_d;
      longint    ax, ay, bx, by, ox, oy, den;
      e  = '0;
      px = longint'($signed(it.px));
      py = longint'($signed(it.py));
      qx = longint'($signed(it.qx));
      qy = longint'($signed(it.qy));
      if (it.func == pnph_pkg::FuncAppend) begin
        if (vert_cnt >= StoreDepth) begin
          e.status = pnph_pkg::StatusFull;
        end else begin
          vert_x[vert_cnt] = px;
          vert_y[vert_cnt] = py;
          vert_cnt++;
        end
      end else if (it.func == pnph_pkg::FuncClear) begin
        vert_cnt = 0;
      end else if (vert_cnt < 2) begin
        e.status = pnph_pkg::StatusFew;
      end else if (it.func == pnph_pkg::FuncNearest) begin
        best_d = -1;
        bestx  = 0;
        besty  = 0;
        for (int unsigned i = 0; i + 1 < vert_cnt; i++) begin
          seg_candidate(i, px, py, cx, cy);
          sq_d = (cx - px * 256) * (cx - px * 256) + (cy - py * 256) * (cy - py * 256);
          if (best_d < 0 || sq_d < best_d) begin
            best_d = sq_d;
            bestx  = cx;
            besty  = cy;
          end
        end
        e.near_x = bestx[pnph_pkg::OutBits-1:0];
        e.near_y = besty[pnph_pkg::OutBits-1:0];
      end else begin
        for (int unsigned i = 0; i + 1 < vert_cnt; i++) begin
          ax  = vert_x[i+1] - vert_x[i];
          ay  = vert_y[i+1] - vert_y[i];
          bx  = px - qx;
          by  = py - qy;
          ox  = vert_x[i] - px;
          oy  = vert_y[i] - py;
          den = ay * bx - ax * by;
          if (den != 0 && in_unit(by * ox - bx * oy, den) && in_unit(ax * oy - ay * ox, den)) begin
            e.hit = 1'b1;
            break;
          end
        end
      end
      expected_q = {expected_q, e};
    endfunction

    // Compares a result item with the oldest expectation.
    function void check_result(pnph_pkg::out_item_t got);
      pnph_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", got);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.near_x !== e.near_x ||
          got.near_y !== e.near_y || got.hit !== e.hit) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
      end
    endfunction
  endclass

  logic                clk, rst_n;
  logic                in_valid, in_ready, out_valid, out_ready;
  pnph_pkg::in_item_t  in_data;
  pnph_pkg::out_item_t out_data;

  polyline_scoreboard sb = new();
  int unsigned        sent_cnt;
  int unsigned        send_idle, recv_idle;
  int unsigned        quiet_cycles;

  polyline_nearest_point_and_hit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Monitor both channels, drive the receiver's ready and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Sends one item, idling first at the current rate, and waits for acceptance.
  task automatic send_item(logic [1:0] func, shortint px, shortint py,
                           shortint qx = 0, shortint qy = 0);
    if (sent_cnt < NumItems / 3) begin
      send_idle = 32;
      recv_idle = 78;
    end else if (sent_cnt < 2 * NumItems / 3) begin
      send_idle = 78;
      recv_idle = 32;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data.func  <= func;
    in_data.px    <= px;
    in_data.py    <= py;
    in_data.qx    <= qx;
    in_data.qy    <= qy;
    do @(posedge clk); while (!in_ready);
    sent_cnt++;
  endtask

  // Coordinate drawn from the whole range, a small window or the extremes.
  function automatic shortint pick_coord(int unsigned mode);
    case (mode)
      0:       return shortint'($urandom());
      1:       return shortint'($urandom_range(40)) - 16'sd20;
      default: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sd32767;
          2:       return 16'sd0;
          default: return -16'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic run_directed();
    // Queries on an empty store and on a single vertex.
    send_item(pnph_pkg::FuncNearest, 0, 0);
    send_item(pnph_pkg::FuncIntersect, 0, 0, 1, 1);
    send_item(pnph_pkg::FuncAppend, 0, 0);
    send_item(pnph_pkg::FuncNearest, 3, 3);
    // Degenerate segment gives its end vertex.
    send_item(pnph_pkg::FuncAppend, 0, 0);
    send_item(pnph_pkg::FuncNearest, 5, 5);
    send_item(pnph_pkg::FuncIntersect, -5, 0, 5, 0);
    // Extreme diagonal with inexact projections of both signs.
    send_item(pnph_pkg::FuncClear, 0, 0);
    send_item(pnph_pkg::FuncAppend, -32768, -32768);
    send_item(pnph_pkg::FuncAppend, 32767, 32767);
    send_item(pnph_pkg::FuncNearest, -32768, 32767);
    send_item(pnph_pkg::FuncNearest, 32767, -32768);
    send_item(pnph_pkg::FuncNearest, -32768, -32768);
    send_item(pnph_pkg::FuncAppend, 32767, -32768);
    send_item(pnph_pkg::FuncIntersect, -32768, 0, 32767, 0);
    // Collinear overlap is a miss; touching a vertex is a hit.
    send_item(pnph_pkg::FuncIntersect, -32768, -32768, 0, 0);
    send_item(pnph_pkg::FuncIntersect, 32767, 32767, 0, 32767);
    // Projection beyond the start, and a tie between two segments.
    send_item(pnph_pkg::FuncClear, 0, 0);
    send_item(pnph_pkg::FuncAppend, 0, 0);
    send_item(pnph_pkg::FuncAppend, 10, 0);
    send_item(pnph_pkg::FuncAppend, 0, 0);
    send_item(pnph_pkg::FuncNearest, -5, 3);
    send_item(pnph_pkg::FuncNearest, 5, 5);
    send_item(pnph_pkg::FuncIntersect, 3, -7, 7, 9);
    send_item(pnph_pkg::FuncClear, 0, 0);
  endtask

  // Fills the store, overflows it, then queries the full polyline.
  task automatic run_full_store();
    send_item(pnph_pkg::FuncClear, 0, 0);
    for (int i = 0; i < StoreDepth; i++) begin
      send_item(pnph_pkg::FuncAppend, pick_coord(1), pick_coord(1));
    end
    send_item(pnph_pkg::FuncAppend, pick_coord(0), pick_coord(0));
    send_item(pnph_pkg::FuncAppend, pick_coord(2), pick_coord(2));
    send_item(pnph_pkg::FuncNearest, pick_coord(1), pick_coord(1));
    send_item(pnph_pkg::FuncIntersect, pick_coord(1), pick_coord(1), pick_coord(1),
              pick_coord(1));
    send_item(pnph_pkg::FuncClear, 0, 0);
  endtask

  task automatic run_random();
    int unsigned mode, nverts, nq;
    bit          filled;
    filled = 1'b0;
    while (sent_cnt < NumItems) begin
      if (!filled && sent_cnt > NumItems / 2) begin
        run_full_store();
        filled = 1'b1;
      end else if ($urandom_range(99) < 80) begin
        // Well-formed: fresh polyline, then a few queries against it.
        mode   = $urandom_range(2);
        nverts = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
        nq     = $urandom_range(1, 6);
        send_item(pnph_pkg::FuncClear, pick_coord(0), pick_coord(0), pick_coord(0),
                  pick_coord(0));
        repeat (nverts) send_item(pnph_pkg::FuncAppend, pick_coord(mode), pick_coord(mode),
                                  pick_coord(0), pick_coord(0));
        repeat (nq) begin
          mode = $urandom_range(2);
          send_item($urandom_range(1) ? pnph_pkg::FuncNearest : pnph_pkg::FuncIntersect,
                    pick_coord(mode), pick_coord(mode), pick_coord(mode), pick_coord(mode));
        end
      end else begin
        send_item(2'($urandom_range(3)), pick_coord(0), pick_coord(0),
                  pick_coord(0), pick_coord(0));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    sent_cnt     = 0;
    send_idle    = 32;
    recv_idle    = 78;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
